/* rtl/tms_pkg.sv */
// Shared types, codes and the control store of the Turing machine step block.
package tms_pkg;

  localparam int NAME_SLOTS_DEF = 16;
  localparam int TAPE_CELLS_DEF = 256;

  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_HALT  = 8'h48;
  localparam logic [7:0] CH_RIGHT = 8'h52;
  localparam logic [7:0] CH_LEFT  = 8'h4C;

  typedef enum logic [2:0] {
    MODE_ADD_STATE  = 3'd0,
    MODE_ADD_SYMBOL = 3'd1,
    MODE_SET_RULE   = 3'd2,
    MODE_WRITE_TAPE = 3'd3,
    MODE_SET_HEAD   = 3'd4,
    MODE_STEP       = 3'd5
  } tms_mode_e;

  typedef enum logic [2:0] {
    STAT_ACCEPTED     = 3'd0,
    STAT_STEPPED      = 3'd1,
    STAT_HALTED       = 3'd2,
    STAT_NO_RULE      = 3'd3,
    STAT_LIST_FULL    = 3'd4,
    STAT_NAME_UNKNOWN = 3'd5,
    STAT_HEAD_EDGE    = 3'd6
  } tms_status_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] state_char;
    logic [7:0] symbol_char;
    logic [7:0] next_state_char;
    logic [7:0] next_symbol_char;
    logic [7:0] move_code;
    logic [7:0] tape_addr;
  } tms_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] head_position;
    logic [7:0] current_state_name;
    logic [7:0] read_symbol;
    logic [7:0] written_symbol;
  } tms_out_t;

  typedef struct packed {
    logic [7:0] next_state;
    logic [7:0] next_symbol;
    logic [7:0] move;
  } tms_rule_t;

  // status of one name list toward the sequencer
  typedef struct packed {
    logic       full;
    logic       hit;
    logic       slot_valid;
    logic [7:0] slot_name;
  } tms_list_stat_t;

  typedef enum logic [1:0] {
    PH_CLEAR = 2'd0,
    PH_IDLE  = 2'd1,
    PH_RUN   = 2'd2
  } tms_phase_e;

  typedef enum logic [3:0] {
    UOP_NOP         = 4'd0,
    UOP_ADD_STATE   = 4'd1,
    UOP_ADD_SYMBOL  = 4'd2,
    UOP_SET_RULE    = 4'd3,
    UOP_WRITE_TAPE  = 4'd4,
    UOP_SET_HEAD    = 4'd5,
    UOP_TAPE_RD     = 4'd6,
    UOP_RULE_RD     = 4'd7,
    UOP_RULE_CHECK  = 4'd8,
    UOP_STEP_COMMIT = 4'd9,
    UOP_EMIT        = 4'd10
  } tms_uop_e;

  typedef enum logic {
    STKEY_ITEM = 1'b0,
    STKEY_RULE = 1'b1
  } tms_stkey_e;

  typedef enum logic {
    SYKEY_ITEM = 1'b0,
    SYKEY_READ = 1'b1
  } tms_sykey_e;

  typedef enum logic [1:0] {
    BR_NEXT   = 2'd0,
    BR_ERR    = 2'd1,
    BR_ALWAYS = 2'd2
  } tms_br_e;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] tms_upc_t;

  localparam tms_upc_t UA_ADD_STATE   = 4'd0;
  localparam tms_upc_t UA_ADD_SYMBOL  = 4'd1;
  localparam tms_upc_t UA_RULE_MATCH  = 4'd2;
  localparam tms_upc_t UA_RULE_SET    = 4'd3;
  localparam tms_upc_t UA_WRITE_TAPE  = 4'd4;
  localparam tms_upc_t UA_HEAD_MATCH  = 4'd5;
  localparam tms_upc_t UA_HEAD_SET    = 4'd6;
  localparam tms_upc_t UA_STEP_READ   = 4'd7;
  localparam tms_upc_t UA_STEP_SYM    = 4'd8;
  localparam tms_upc_t UA_STEP_RULE   = 4'd9;
  localparam tms_upc_t UA_STEP_CHECK  = 4'd10;
  localparam tms_upc_t UA_STEP_COMMIT = 4'd11;
  localparam tms_upc_t UA_EMIT        = 4'd12;

  typedef struct packed {
    tms_uop_e   uop;
    tms_stkey_e st_key;
    tms_sykey_e sy_key;
    tms_br_e    br;
    tms_upc_t   target;
  } tms_uword_t;

  function automatic tms_uword_t uw(tms_uop_e op, tms_stkey_e sk, tms_sykey_e yk,
                                    tms_br_e br, tms_upc_t tgt);
    tms_uword_t w;
    w.uop    = op;
    w.st_key = sk;
    w.sy_key = yk;
    w.br     = br;
    w.target = tgt;
    return w;
  endfunction

  // control store: one word per micro-step
  function automatic tms_uword_t ucode(tms_upc_t addr);
    tms_uword_t w;
    case (addr)
      UA_ADD_STATE:   w = uw(UOP_ADD_STATE, STKEY_ITEM, SYKEY_ITEM, BR_ALWAYS, UA_EMIT);
      UA_ADD_SYMBOL:  w = uw(UOP_ADD_SYMBOL, STKEY_ITEM, SYKEY_ITEM, BR_ALWAYS, UA_EMIT);
      UA_RULE_MATCH:  w = uw(UOP_NOP, STKEY_ITEM, SYKEY_ITEM, BR_NEXT, UA_EMIT);
      UA_RULE_SET:    w = uw(UOP_SET_RULE, STKEY_ITEM, SYKEY_ITEM, BR_ALWAYS, UA_EMIT);
      UA_WRITE_TAPE:  w = uw(UOP_WRITE_TAPE, STKEY_ITEM, SYKEY_ITEM, BR_ALWAYS, UA_EMIT);
      UA_HEAD_MATCH:  w = uw(UOP_NOP, STKEY_ITEM, SYKEY_ITEM, BR_NEXT, UA_EMIT);
      UA_HEAD_SET:    w = uw(UOP_SET_HEAD, STKEY_ITEM, SYKEY_ITEM, BR_ALWAYS, UA_EMIT);
      UA_STEP_READ:   w = uw(UOP_TAPE_RD, STKEY_ITEM, SYKEY_ITEM, BR_NEXT, UA_EMIT);
      UA_STEP_SYM:    w = uw(UOP_NOP, STKEY_ITEM, SYKEY_READ, BR_NEXT, UA_EMIT);
      UA_STEP_RULE:   w = uw(UOP_RULE_RD, STKEY_ITEM, SYKEY_READ, BR_ERR, UA_EMIT);
      UA_STEP_CHECK:  w = uw(UOP_RULE_CHECK, STKEY_RULE, SYKEY_READ, BR_ERR, UA_EMIT);
      UA_STEP_COMMIT: w = uw(UOP_STEP_COMMIT, STKEY_RULE, SYKEY_READ, BR_ALWAYS, UA_EMIT);
      default:        w = uw(UOP_EMIT, STKEY_ITEM, SYKEY_ITEM, BR_NEXT, UA_EMIT);
    endcase
    return w;
  endfunction

  // entry point of the program for each mode
  function automatic tms_upc_t dispatch(logic [2:0] mode);
    tms_upc_t a;
    case (tms_mode_e'(mode))
      MODE_ADD_STATE:  a = UA_ADD_STATE;
      MODE_ADD_SYMBOL: a = UA_ADD_SYMBOL;
      MODE_SET_RULE:   a = UA_RULE_MATCH;
      MODE_WRITE_TAPE: a = UA_WRITE_TAPE;
      MODE_SET_HEAD:   a = UA_HEAD_MATCH;
      MODE_STEP:       a = UA_STEP_READ;
      default:         a = UA_EMIT;
    endcase
    return a;
  endfunction

endpackage

/* rtl/tms_stream_if.sv */
// Valid/ready stream channel carrying one payload struct.
interface tms_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tms_name_list.sv */
// Append-only name list with registered match vector and first-hit encoder.
module tms_name_list #(
  parameter int NAME_SLOTS = tms_pkg::NAME_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          add_i,
  input  logic [7:0]                    add_char_i,
  input  logic [7:0]                    key_i,
  input  logic [$clog2(NAME_SLOTS)-1:0] slot_idx_i,
  output tms_pkg::tms_list_stat_t       stat_o,
  output logic [$clog2(NAME_SLOTS)-1:0] hit_idx_o
);
  import tms_pkg::*;

  localparam int IDX_W = $clog2(NAME_SLOTS);
  localparam int CNT_W = $clog2(NAME_SLOTS + 1);

  logic [7:0]            names_q [NAME_SLOTS];
  logic [CNT_W-1:0]      count_q;
  logic [NAME_SLOTS-1:0] hit_vec_q;
  logic                  full;
  logic                  slot_valid;

  assign full       = (count_q == CNT_W'(NAME_SLOTS));
  assign slot_valid = (CNT_W'(slot_idx_i) < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (add_i && !full) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_i && !full) begin
      names_q[count_q[IDX_W-1:0]] <= add_char_i;
    end
  end

  // compare every registered entry against the key, register the hits
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NAME_SLOTS; i++) begin
      hit_vec_q[i] <= (CNT_W'(i) < count_q) && (names_q[i] == key_i);
    end
  end

  // lowest hit wins
  always_comb begin
    hit_idx_o = '0;
    for (int i = NAME_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec_q[i]) begin
        hit_idx_o = IDX_W'(i);
      end
    end
  end

  always_comb begin
    stat_o.full       = full;
    stat_o.hit        = |hit_vec_q;
    stat_o.slot_valid = slot_valid;
    stat_o.slot_name  = slot_valid ? names_q[slot_idx_i] : CH_BLANK;
  end

endmodule

/* rtl/turing_machine_step.sv */
// Top level: microcoded Turing machine with name lists, rule memory and tape.
//
//   channel  dir  port   payload    transfer when
//   -------  ---  -----  ---------  ----------------------------
//   item     in   in_i   tms_in_t   in_i.valid && in_i.ready
//   result   out  out_o  tms_out_t  out_o.valid && out_o.ready
//
// One item at a time. An item transfers in, then runs a short microprogram:
// add name and tape write act and then go to the result step, set rule and
// set head match names first, and a step runs tape read, symbol match, rule
// read, rule check, commit, result; error exits jump straight to the result step.
// The step is bounded by the registered tape read followed by the rule read.
// After reset a clearing pass writes blank into every tape cell and every
// rule entry, while in_i.ready stays low.
// The result sits in an output register; a stalled result holds the
// sequencer at its result step, and in_i.ready returns once it moves out.
module turing_machine_step #(
  parameter int NAME_SLOTS = tms_pkg::NAME_SLOTS_DEF,
  parameter int TAPE_CELLS = tms_pkg::TAPE_CELLS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tms_stream_if.sink   in_i,
  tms_stream_if.source out_o
);
  import tms_pkg::*;

  localparam int IDX_W      = $clog2(NAME_SLOTS);
  localparam int RULE_AW    = 2 * IDX_W;
  localparam int RULE_WORDS = 1 << RULE_AW;
  localparam int HEAD_W     = $clog2(TAPE_CELLS);
  localparam int CLR_LEN    = (RULE_WORDS > TAPE_CELLS) ? RULE_WORDS : TAPE_CELLS;
  localparam int CLR_W      = $clog2(CLR_LEN);

  // control
  tms_phase_e phase_q, phase_d;
  tms_upc_t   upc_q, upc_d;
  logic [CLR_W-1:0] clr_q;
  logic       clearing, running, clr_last;
  logic       in_fire, emit_fire;
  tms_uword_t uword;
  logic       err;

  // architectural state and item
  tms_in_t          item_q;
  logic [HEAD_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  tms_status_e      status_q, status_d;
  logic [7:0]       wr_q, wr_d;
  logic             addr_ok;
  logic             at_left, at_right;

  // result register
  logic     out_valid_q;
  tms_out_t out_q;

  // name lists
  logic            st_add, sy_add;
  logic [7:0]      st_key, sy_key;
  tms_list_stat_t  st_stat, sy_stat;
  logic [IDX_W-1:0] st_hit_idx, sy_hit_idx;

  // memories
  logic [7:0]        tape_mem [TAPE_CELLS];
  tms_rule_t         rule_mem [RULE_WORDS];
  logic              tape_we, tape_re, rule_we, rule_re;
  logic [HEAD_W-1:0] tape_waddr;
  logic [7:0]        tape_wdata, tape_rdata_q;
  logic [RULE_AW-1:0] rule_waddr, rule_raddr;
  tms_rule_t         rule_wdata, rule_rdata_q;

  assign uword     = ucode(upc_q);
  assign in_fire   = in_i.valid && in_i.ready;
  assign emit_fire = running && (uword.uop == UOP_EMIT) && (!out_valid_q || out_o.ready);
  assign clr_last  = (clr_q == CLR_W'(CLR_LEN - 1));
  assign addr_ok   = (32'(item_q.tape_addr) < TAPE_CELLS);
  assign at_left   = (head_q == '0);
  assign at_right  = (head_q == HEAD_W'(TAPE_CELLS - 1));

  // ---------------------------------------------------------------------
  // phase control: clearing pass, idle, program run
  // ---------------------------------------------------------------------
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_CLEAR: if (clr_last) phase_d = PH_IDLE;
      PH_IDLE:  if (in_fire) phase_d = PH_RUN;
      PH_RUN:   if (emit_fire) phase_d = PH_IDLE;
      default:  phase_d = PH_CLEAR;
    endcase
  end

  always_comb begin
    clearing   = (phase_q == PH_CLEAR);
    running    = (phase_q == PH_RUN);
    in_i.ready = (phase_q == PH_IDLE);
  end

  // ---------------------------------------------------------------------
  // name list keys follow the control word
  // ---------------------------------------------------------------------
  always_comb begin
    st_key = (uword.st_key == STKEY_RULE) ? rule_rdata_q.next_state : item_q.state_char;
    sy_key = (uword.sy_key == SYKEY_READ) ? tape_rdata_q : item_q.symbol_char;
  end

  tms_name_list #(.NAME_SLOTS(NAME_SLOTS)) u_state_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .add_i      (st_add),
    .add_char_i (item_q.state_char),
    .key_i      (st_key),
    .slot_idx_i (slot_q),
    .stat_o     (st_stat),
    .hit_idx_o  (st_hit_idx)
  );

  tms_name_list #(.NAME_SLOTS(NAME_SLOTS)) u_symbol_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .add_i      (sy_add),
    .add_char_i (item_q.symbol_char),
    .key_i      (sy_key),
    .slot_idx_i ('0),
    .stat_o     (sy_stat),
    .hit_idx_o  (sy_hit_idx)
  );

  // ---------------------------------------------------------------------
  // datapath actions of the current micro-step and the branch
  // ---------------------------------------------------------------------
  always_comb begin
    err        = 1'b0;
    status_d   = status_q;
    head_d     = head_q;
    slot_d     = slot_q;
    wr_d       = wr_q;
    upc_d      = upc_q;
    st_add     = 1'b0;
    sy_add     = 1'b0;
    tape_we    = 1'b0;
    tape_re    = 1'b0;
    tape_waddr = head_q;
    tape_wdata = rule_rdata_q.next_symbol;
    rule_we    = 1'b0;
    rule_re    = 1'b0;
    rule_waddr = {st_hit_idx, sy_hit_idx};
    rule_raddr = {slot_q, sy_hit_idx};
    rule_wdata.next_state  = item_q.next_state_char;
    rule_wdata.next_symbol = item_q.next_symbol_char;
    rule_wdata.move        = item_q.move_code;

    if (clearing) begin
      // blank one tape cell and one rule entry per cycle
      tape_we    = ({1'b0, clr_q} < (CLR_W + 1)'(TAPE_CELLS));
      tape_waddr = clr_q[HEAD_W-1:0];
      tape_wdata = CH_BLANK;
      rule_we    = 1'b1;
      rule_waddr = clr_q[RULE_AW-1:0];
      rule_wdata.next_state  = CH_BLANK;
      rule_wdata.next_symbol = '0;
      rule_wdata.move        = '0;
    end

    if (in_fire) begin
      status_d = STAT_ACCEPTED;
      wr_d     = '0;
      upc_d    = dispatch(in_i.data.mode);
    end

    if (running) begin
      case (uword.uop)
        UOP_ADD_STATE: begin
          if (st_stat.full) status_d = STAT_LIST_FULL;
          else st_add = 1'b1;
        end
        UOP_ADD_SYMBOL: begin
          if (sy_stat.full) status_d = STAT_LIST_FULL;
          else sy_add = 1'b1;
        end
        UOP_SET_RULE: begin
          if (!(st_stat.hit && sy_stat.hit)) status_d = STAT_NAME_UNKNOWN;
          else rule_we = 1'b1;
        end
        UOP_WRITE_TAPE: begin
          if (!addr_ok) begin
            status_d = STAT_HEAD_EDGE;
          end else begin
            tape_we    = 1'b1;
            tape_waddr = HEAD_W'(item_q.tape_addr);
            tape_wdata = item_q.symbol_char;
          end
        end
        UOP_SET_HEAD: begin
          if (!st_stat.hit) begin
            status_d = STAT_NAME_UNKNOWN;
          end else if (!addr_ok) begin
            status_d = STAT_HEAD_EDGE;
          end else begin
            head_d = HEAD_W'(item_q.tape_addr);
            slot_d = st_hit_idx;
          end
        end
        UOP_TAPE_RD: begin
          tape_re = 1'b1;
        end
        UOP_RULE_RD: begin
          // the current slot is always the first copy of its name
          if (!(st_stat.slot_valid && sy_stat.hit)) begin
            err      = 1'b1;
            status_d = STAT_NAME_UNKNOWN;
          end else begin
            rule_re = 1'b1;
          end
        end
        UOP_RULE_CHECK: begin
          if (rule_rdata_q.next_state == CH_BLANK) begin
            err      = 1'b1;
            status_d = STAT_NO_RULE;
          end else if (rule_rdata_q.move == CH_HALT) begin
            err      = 1'b1;
            status_d = STAT_HALTED;
          end
        end
        UOP_STEP_COMMIT: begin
          if (!st_stat.hit) begin
            status_d = STAT_NAME_UNKNOWN;
          end else if ((rule_rdata_q.move == CH_RIGHT && at_right) ||
                       (rule_rdata_q.move == CH_LEFT && at_left)) begin
            status_d = STAT_HEAD_EDGE;
          end else begin
            tape_we  = 1'b1;
            wr_d     = rule_rdata_q.next_symbol;
            slot_d   = st_hit_idx;
            status_d = STAT_STEPPED;
            if (rule_rdata_q.move == CH_RIGHT) head_d = head_q + HEAD_W'(1);
            else if (rule_rdata_q.move == CH_LEFT) head_d = head_q - HEAD_W'(1);
          end
        end
        default: ;
      endcase

      // sequencing: hold on the result step, otherwise advance or jump
      if (uword.uop != UOP_EMIT) begin
        case (uword.br)
          BR_NEXT:   upc_d = upc_q + UPC_W'(1);
          BR_ERR:    upc_d = err ? uword.target : upc_q + UPC_W'(1);
          BR_ALWAYS: upc_d = uword.target;
          default:   upc_d = uword.target;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLEAR;
      upc_q       <= UA_EMIT;
      clr_q       <= '0;
      head_q      <= '0;
      slot_q      <= '0;
      status_q    <= STAT_ACCEPTED;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      upc_q    <= upc_d;
      head_q   <= head_d;
      slot_q   <= slot_d;
      status_q <= status_d;
      if (clearing) clr_q <= clr_q + CLR_W'(1);
      if (emit_fire) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q <= wr_d;
    if (in_fire) item_q <= in_i.data;
    if (emit_fire) begin
      out_q.status             <= status_q;
      out_q.head_position      <= 8'(head_q);
      out_q.current_state_name <= st_stat.slot_name;
      out_q.read_symbol        <= (tms_mode_e'(item_q.mode) == MODE_STEP) ? tape_rdata_q : '0;
      out_q.written_symbol     <= wr_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // tape memory: one write port, one registered read at the head
  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    if (tape_re) tape_rdata_q <= tape_mem[head_q];
  end

  // rule memory indexed by {state slot, symbol slot}
  always_ff @(posedge clk_i) begin
    if (rule_we) rule_mem[rule_waddr] <= rule_wdata;
    if (rule_re) rule_rdata_q <= rule_mem[rule_raddr];
  end

`ifndef SYNTHESIS
  // a delivered result always ends the program
  a_emit_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (phase_q == PH_IDLE))
    else $error("sequencer did not return to idle after its result");

  // the head never leaves the tape
  a_head_on_tape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= HEAD_W'(TAPE_CELLS - 1))
    else $error("head index beyond the last tape cell");

  // the program counter stays inside the control store while running
  a_upc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running |-> (upc_q <= UA_EMIT))
    else $error("micro program counter outside the program");

  // no item transfers in while a result still has to be produced
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running && !emit_fire) |=> !in_fire)
    else $error("item accepted while the previous one is running");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the table-driven Turing machine step block.
module tb_top;
  import tms_pkg::*;

  localparam int NAME_SLOTS   = NAME_SLOTS_DEF;
  localparam int TAPE_CELLS   = TAPE_CELLS_DEF;
  localparam int RANDOM_ITEMS = 1100;
  // The watchdog limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT  = 600000;

  // Modes 6 and 7 have no meaning; the block answers them with a plain accept.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;

  tms_stream_if #(.payload_t(tms_in_t))  item_if ();
  tms_stream_if #(.payload_t(tms_out_t)) result_if ();

  turing_machine_step dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (item_if),
    .out_o (result_if)
  );

  // Period of 2: high for one unit, low for one unit.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Machine model: name lists, rule memory, tape, head and current state slot.
  // ---------------------------------------------------------------------------
  logic [7:0] st_names [NAME_SLOTS];
  logic [7:0] sy_names [NAME_SLOTS];
  int         st_cnt;
  int         sy_cnt;
  tms_rule_t  rule_mem [NAME_SLOTS*NAME_SLOTS];
  logic [7:0] tape [TAPE_CELLS];
  int         head_idx;
  int         cur_slot;

  tms_out_t   expected_results [$];
  int         error_count = 0;
  int         items_sent  = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;
  int         rx_phase    = 0;
  int         rx_left     = 0;
  tms_out_t   got;
  tms_out_t   want;

  task automatic clear_machine_model();
    for (int i = 0; i < NAME_SLOTS; i++) begin
      st_names[i] = CH_BLANK;
      sy_names[i] = CH_BLANK;
    end
    for (int i = 0; i < NAME_SLOTS*NAME_SLOTS; i++) begin
      rule_mem[i] = '{next_state: CH_BLANK, next_symbol: 8'h00, move: 8'h00};
    end
    for (int i = 0; i < TAPE_CELLS; i++) tape[i] = CH_BLANK;
    st_cnt   = 0;
    sy_cnt   = 0;
    head_idx = 0;
    cur_slot = 0;
  endtask

  // Search only the registered part of a list; the first match wins, so a
  // duplicate registered later is never found.
  function automatic int lookup_name(input bit in_states, input logic [7:0] ch);
    for (int i = 0; i < (in_states ? st_cnt : sy_cnt); i++) begin
      if ((in_states ? st_names[i] : sy_names[i]) == ch) return i;
    end
    return -1;
  endfunction

  // Apply one item to the machine model and return the result it must give.
  function automatic tms_out_t apply_machine_item(input tms_in_t it);
    tms_out_t  r;
    tms_rule_t ru;
    int        ps;
    int        pc;
    int        pn;
    int        h;
    r = '0;
    r.status = STAT_ACCEPTED;
    case (it.mode)
      MODE_ADD_STATE: begin
        if (st_cnt >= NAME_SLOTS) r.status = STAT_LIST_FULL;
        else begin
          st_names[st_cnt] = it.state_char;
          st_cnt++;
        end
      end
      MODE_ADD_SYMBOL: begin
        if (sy_cnt >= NAME_SLOTS) r.status = STAT_LIST_FULL;
        else begin
          sy_names[sy_cnt] = it.symbol_char;
          sy_cnt++;
        end
      end
      MODE_SET_RULE: begin
        ps = lookup_name(1'b1, it.state_char);
        pc = lookup_name(1'b0, it.symbol_char);
        if (ps < 0 || pc < 0) r.status = STAT_NAME_UNKNOWN;
        else rule_mem[ps*NAME_SLOTS + pc] = '{next_state: it.next_state_char,
                                              next_symbol: it.next_symbol_char,
                                              move: it.move_code};
      end
      MODE_WRITE_TAPE: begin
        if (int'(it.tape_addr) >= TAPE_CELLS) r.status = STAT_HEAD_EDGE;
        else tape[it.tape_addr] = it.symbol_char;
      end
      MODE_SET_HEAD: begin
        ps = lookup_name(1'b1, it.state_char);
        if (ps < 0) r.status = STAT_NAME_UNKNOWN;
        else if (int'(it.tape_addr) >= TAPE_CELLS) r.status = STAT_HEAD_EDGE;
        else begin
          head_idx = int'(it.tape_addr);
          cur_slot = ps;
        end
      end
      MODE_STEP: begin
        h = head_idx % TAPE_CELLS;
        r.read_symbol = tape[h];
        ps = -1;
        if (cur_slot < st_cnt) ps = lookup_name(1'b1, st_names[cur_slot]);
        pc = lookup_name(1'b0, tape[h]);
        if (ps < 0 || pc < 0) r.status = STAT_NAME_UNKNOWN;
        else begin
          ru = rule_mem[ps*NAME_SLOTS + pc];
          pn = lookup_name(1'b1, ru.next_state);
          if (ru.next_state == CH_BLANK) r.status = STAT_NO_RULE;
          else if (ru.move == CH_HALT) r.status = STAT_HALTED;
          else if (pn < 0) r.status = STAT_NAME_UNKNOWN;
          else if ((ru.move == CH_RIGHT && h + 1 >= TAPE_CELLS) ||
                   (ru.move == CH_LEFT && h == 0)) r.status = STAT_HEAD_EDGE;
          else begin
            tape[h] = ru.next_symbol;
            r.written_symbol = ru.next_symbol;
            if (ru.move == CH_RIGHT) h++;
            else if (ru.move == CH_LEFT) h--;
            head_idx = h;
            cur_slot = pn;
            r.status = STAT_STEPPED;
          end
        end
      end
      default: ;
    endcase
    r.head_position      = head_idx[7:0];
    r.current_state_name = st_names[cur_slot];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item driver: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------
  task automatic send_item(input tms_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // A quarter of the bursts follow the previous one with no gap at all.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) item_if.valid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    // Hold the item until the block takes it.
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    expected_results.push_back(apply_machine_item(it));
    if (it.mode < MODE_SPARE_LO) items_sent++;
  endtask

  // Drop valid and hold off until every expected result has been checked.
  task automatic drain_results();
    @(negedge clk) item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic tms_in_t make_item(input logic [2:0] mode, input logic [7:0] st,
                                        input logic [7:0] sy, input logic [7:0] nst,
                                        input logic [7:0] nsy, input logic [7:0] mv,
                                        input logic [7:0] addr);
    return '{mode: mode, state_char: st, symbol_char: sy, next_state_char: nst,
             next_symbol_char: nsy, move_code: mv, tape_addr: addr};
  endfunction

  function automatic tms_in_t rand_item();
    return make_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] pick_state();
    if (st_cnt == 0) return 8'h41;
    return st_names[$urandom_range(0, st_cnt - 1)];
  endfunction

  function automatic logic [7:0] pick_symbol();
    if (sy_cnt == 0) return CH_BLANK;
    return sy_names[$urandom_range(0, sy_cnt - 1)];
  endfunction

  function automatic logic [7:0] pick_move();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CH_RIGHT;
    if (r < 80) return CH_LEFT;
    if (r < 86) return CH_HALT;
    return 8'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got_v, want_v,
             cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got.status), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.head_position !== want.head_position)
          report_mismatch("head_position", int'(got.head_position),
                          int'(want.head_position));
        if (got.current_state_name !== want.current_state_name)
          report_mismatch("current_state_name", int'(got.current_state_name),
                          int'(want.current_state_name));
        if (got.read_symbol !== want.read_symbol)
          report_mismatch("read_symbol", int'(got.read_symbol), int'(want.read_symbol));
        if (got.written_symbol !== want.written_symbol)
          report_mismatch("written_symbol", int'(got.written_symbol),
                          int'(want.written_symbol));
      end
    end
  end

  // Result ready: switch among always ready, mostly ready, mostly stalled and a
  // square wave, each held for a random stretch.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_phase <= $urandom_range(0, 3);
      rx_left  <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_phase)
      0:       result_if.ready <= 1'b1;
      1:       result_if.ready <= ($urandom_range(0, 3) != 0);
      2:       result_if.ready <= ($urandom_range(0, 3) == 0);
      default: result_if.ready <= cycle_count[2];
    endcase
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Before any name exists: steps, rules and head moves must all be refused,
  // spare modes accepted, and a tape write lands at the first cell.
  task automatic test_before_names();
    send_item(make_item(MODE_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_SET_RULE, 8'h41, CH_BLANK, 8'h42, 8'h31, CH_RIGHT, 8'h00));
    send_item(make_item(MODE_SET_HEAD, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05));
    send_item(make_item(MODE_SPARE_LO, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(MODE_WRITE_TAPE, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    drain_results();
  endtask

  // Register names, extreme codes and a duplicate among them.
  task automatic test_name_registration();
    send_item(make_item(MODE_ADD_STATE, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_ADD_STATE, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_ADD_STATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_ADD_STATE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_ADD_STATE, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_ADD_SYMBOL, 8'h00, CH_BLANK, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_ADD_SYMBOL, 8'h00, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_ADD_SYMBOL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    drain_results();
  endtask

  // A short program: move right, move left, stay in place, then halt.
  task automatic test_rule_steps();
    send_item(make_item(MODE_SET_RULE, 8'h41, CH_BLANK, 8'h42, 8'h31, CH_RIGHT, 8'h00));
    send_item(make_item(MODE_SET_RULE, 8'h42, CH_BLANK, 8'h41, 8'h00, CH_LEFT, 8'h00));
    send_item(make_item(MODE_SET_RULE, 8'h41, 8'h31, 8'hFF, 8'h31, 8'h53, 8'h00));
    send_item(make_item(MODE_SET_RULE, 8'hFF, 8'h31, 8'h41, 8'h31, CH_HALT, 8'h00));
    send_item(make_item(MODE_SET_HEAD, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'd10));
    repeat (4) send_item(make_item(MODE_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    drain_results();
  endtask

  // A move off the left edge, unknown target state, missing rule.
  task automatic test_step_faults();
    send_item(make_item(MODE_SET_RULE, 8'h41, 8'h00, 8'h41, 8'h31, CH_LEFT, 8'h00));
    send_item(make_item(MODE_SET_HEAD, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // Start from the last cell, which still holds blank.
    send_item(make_item(MODE_SET_HEAD, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(MODE_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_WRITE_TAPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(MODE_SET_RULE, 8'h42, 8'h00, 8'h42, CH_BLANK, CH_RIGHT, 8'h00));
    send_item(make_item(MODE_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_SET_RULE, 8'h00, CH_BLANK, 8'h5A, CH_BLANK, CH_RIGHT, 8'h00));
    send_item(make_item(MODE_SET_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd40));
    send_item(make_item(MODE_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_SET_HEAD, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'd10));
    send_item(make_item(MODE_STEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    drain_results();
  endtask

  // Mostly well-formed programs built from registered names: grow the lists
  // now and then, write rules, load a tape window, place the head and run;
  // sprinkle fully random items in between.
  task automatic test_random_programs();
    int stop_at;
    int a;
    int r;
    logic [7:0] h;
    tms_in_t it;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        it = rand_item();
        it.mode = MODE_ADD_STATE;
        if ($urandom_range(0, 9) != 0) it.state_char = 8'(8'h41 + $urandom_range(0, 11));
        send_item(it);
      end
      if ($urandom_range(0, 3) == 0) begin
        it = rand_item();
        it.mode = MODE_ADD_SYMBOL;
        if ($urandom_range(0, 9) != 0) it.symbol_char = 8'(8'h30 + $urandom_range(0, 7));
        send_item(it);
      end
      repeat ($urandom_range(2, 10)) begin
        it = rand_item();
        it.mode = MODE_SET_RULE;
        it.state_char  = pick_state();
        it.symbol_char = pick_symbol();
        r = $urandom_range(0, 99);
        if (r < 85) it.next_state_char = pick_state();
        else if (r < 93) it.next_state_char = CH_BLANK;
        it.next_symbol_char = pick_symbol();
        it.move_code        = pick_move();
        send_item(it);
      end
      // Put the head near an end of the tape one time in five.
      if ($urandom_range(0, 4) == 0)
        h = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(252, 255));
      else
        h = 8'($urandom);
      repeat ($urandom_range(2, 8)) begin
        a = int'(h) + int'($urandom_range(0, 12)) - 6;
        if (a < 0) a = 0;
        if (a > TAPE_CELLS - 1) a = TAPE_CELLS - 1;
        it = rand_item();
        it.mode      = MODE_WRITE_TAPE;
        it.tape_addr = 8'(a);
        if ($urandom_range(0, 9) != 0) it.symbol_char = pick_symbol();
        send_item(it);
      end
      it = rand_item();
      it.mode      = MODE_SET_HEAD;
      it.tape_addr = h;
      if ($urandom_range(0, 19) != 0) it.state_char = pick_state();
      send_item(it);
      repeat ($urandom_range(4, 24)) begin
        it = rand_item();
        it.mode = MODE_STEP;
        send_item(it);
      end
      repeat ($urandom_range(0, 3)) send_item(rand_item());
    end
    drain_results();
  endtask

  // Fill both name lists, push two more into each, then step three more times.
  task automatic test_full_lists();
    tms_in_t it;
    while (st_cnt < NAME_SLOTS + 2) begin
      it = rand_item();
      it.mode = MODE_ADD_STATE;
      send_item(it);
      if (st_cnt == NAME_SLOTS && expected_results[$].status == STAT_LIST_FULL) break;
    end
    repeat (2) begin
      it = rand_item();
      it.mode = MODE_ADD_STATE;
      send_item(it);
    end
    while (sy_cnt < NAME_SLOTS) begin
      it = rand_item();
      it.mode = MODE_ADD_SYMBOL;
      send_item(it);
    end
    repeat (2) begin
      it = rand_item();
      it.mode = MODE_ADD_SYMBOL;
      send_item(it);
    end
    repeat (3) begin
      it = rand_item();
      it.mode = MODE_STEP;
      send_item(it);
    end
    drain_results();
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    item_if.valid   = 1'b0;
    item_if.data    = '0;
    result_if.ready = 1'b0;
    clear_machine_model();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // The block clears its tape and rule memory first; send_item simply waits
    // for ready through that pass.
    test_before_names();
    test_name_registration();
    test_rule_steps();
    test_step_faults();
    test_random_programs();
    test_full_lists();

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/tms_pkg.sv
rtl/tms_stream_if.sv
rtl/tms_name_list.sv
rtl/turing_machine_step.sv
verif/tb_top.sv
